### src/imu_dead_reckoning_step_top_defines.svh
// Assertion macros for the checker module of the dead-reckoning block.
// The macros expect clk_i and rst_ni to exist in the scope where they are used.
`ifndef IMU_DEAD_RECKONING_STEP_TOP_DEFINES_SVH
`define IMU_DEAD_RECKONING_STEP_TOP_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define IDRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define IDRS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

### src/imu_drs_pkg.sv
// Package for the IMU dead-reckoning step: widths, constants, control word and microcode ROM.
// Depends on nothing; used by imu_dead_reckoning_step_top.
package imu_drs_pkg;

  localparam int unsigned AccW  = 64;
  localparam int unsigned MulAW = 36;
  localparam int unsigned MulBW = 16;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam int unsigned TW    = 33;
  localparam int unsigned XW    = 35;
  localparam int unsigned MkW   = 28;
  localparam int unsigned MkHalf = MkW / 2;
  localparam int unsigned StW   = 48;
  localparam int unsigned ThrW  = 15;
  localparam int unsigned MsW   = 10;
  localparam int unsigned PcW   = 5;
  localparam int unsigned CntW  = 3;

  localparam logic [17:0]      VelK      = 18'd164584;
  localparam logic [ThrW-1:0]  ThrReset  = 15'd41;
  localparam logic [6:0]       DivBase   = 7'd125;
  localparam logic [AccW-1:0]  DivBias   = 64'd500;
  localparam int unsigned      DivPre    = 3;
  localparam logic [CntW-1:0]  DivLast   = 3'd6;
  localparam logic [AccW-1:0]  RndHalf16 = 64'd1 << 15;
  localparam logic [AccW-1:0]  RndHalf28 = 64'd1 << 27;
  localparam logic signed [AccW-1:0] OneG  = 64'sh0000_0100_0000_0000;
  localparam logic signed [AccW-1:0] StMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [AccW-1:0] StMin = -64'sh0000_8000_0000_0000;

  localparam logic [PcW-1:0] PcTLoop = 5'd2;
  localparam logic [PcW-1:0] PcALoop = 5'd5;
  localparam logic [PcW-1:0] PcDiv   = 5'd24;

  typedef enum logic [3:0] {
    MA_T_I, MA_T_J, MA_T_K, MA_A_J, MA_A_K, MA_X, MA_VL, MA_VH, MA_K
  } mul_a_e;

  typedef enum logic [2:0] {
    MB_QW, MB_U_J, MB_U_K, MB_MS, MB_MKL, MB_MKH
  } mul_b_e;

  typedef enum logic [3:0] {
    OP_NOP, OP_LD, OP_ADD, OP_SUB, OP_ACCEL, OP_ABS, OP_ABSDB, OP_RND16, OP_RND28,
    OP_DIVPREP, OP_DIV, OP_SGN, OP_VADD, OP_PADD
  } acc_op_e;

  typedef enum logic [1:0] {SH_0, SH_1, SH_14, SH_24} shift_e;
  typedef enum logic [1:0] {WR_NONE, WR_T, WR_X, WR_MK} wr_e;
  typedef enum logic [1:0] {J_NEXT, J_LOOP, J_DIV, J_DONE} jump_e;

  typedef struct packed {
    mul_a_e           mul_a;
    mul_b_e           mul_b;
    acc_op_e          op;
    shift_e           sh;
    wr_e              wr;
    jump_e            jmp;
    logic [PcW-1:0]   target;
  } ctrl_t;

  function automatic logic [1:0] nxt_axis(input logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

  function automatic logic [1:0] prv_axis(input logic [1:0] i);
    return (i == 2'd0) ? 2'd2 : i - 2'd1;
  endfunction

  function automatic ctrl_t mk_cw(input mul_a_e a, input mul_b_e b, input acc_op_e op,
                                  input shift_e sh, input wr_e wr, input jump_e jmp,
                                  input logic [PcW-1:0] target);
    ctrl_t w;
    w.mul_a  = a;
    w.mul_b  = b;
    w.op     = op;
    w.sh     = sh;
    w.wr     = wr;
    w.jmp    = jmp;
    w.target = target;
    return w;
  endfunction

  // The multiplier product is registered, so an accumulate step consumes the
  // product issued by the step before it.
  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t w;
    unique case (pc)
      5'd0:  w = mk_cw(MA_K,   MB_MS,  OP_NOP,     SH_0,  WR_NONE, J_NEXT, '0);
      5'd1:  w = mk_cw(MA_K,   MB_MS,  OP_LD,      SH_0,  WR_MK,   J_NEXT, '0);
      5'd2:  w = mk_cw(MA_A_K, MB_U_J, OP_NOP,     SH_0,  WR_NONE, J_NEXT, '0);
      5'd3:  w = mk_cw(MA_A_J, MB_U_K, OP_LD,      SH_0,  WR_NONE, J_NEXT, '0);
      5'd4:  w = mk_cw(MA_K,   MB_MS,  OP_SUB,     SH_0,  WR_T,    J_LOOP, PcTLoop);
      5'd5:  w = mk_cw(MA_T_I, MB_QW,  OP_NOP,     SH_0,  WR_NONE, J_NEXT, '0);
      5'd6:  w = mk_cw(MA_T_K, MB_U_J, OP_ACCEL,   SH_1,  WR_NONE, J_NEXT, '0);
      5'd7:  w = mk_cw(MA_T_J, MB_U_K, OP_ADD,     SH_1,  WR_NONE, J_NEXT, '0);
      5'd8:  w = mk_cw(MA_K,   MB_MS,  OP_SUB,     SH_1,  WR_NONE, J_NEXT, '0);
      5'd9:  w = mk_cw(MA_K,   MB_MS,  OP_ABSDB,   SH_0,  WR_NONE, J_NEXT, '0);
      5'd10: w = mk_cw(MA_K,   MB_MS,  OP_RND16,   SH_0,  WR_NONE, J_NEXT, '0);
      5'd11: w = mk_cw(MA_K,   MB_MS,  OP_SGN,     SH_0,  WR_X,    J_NEXT, '0);
      5'd12: w = mk_cw(MA_X,   MB_MKL, OP_NOP,     SH_0,  WR_NONE, J_NEXT, '0);
      5'd13: w = mk_cw(MA_X,   MB_MKH, OP_LD,      SH_0,  WR_NONE, J_NEXT, '0);
      5'd14: w = mk_cw(MA_K,   MB_MS,  OP_ADD,     SH_14, WR_NONE, J_NEXT, '0);
      5'd15: w = mk_cw(MA_K,   MB_MS,  OP_ABS,     SH_0,  WR_NONE, J_NEXT, '0);
      5'd16: w = mk_cw(MA_K,   MB_MS,  OP_RND28,   SH_0,  WR_NONE, J_NEXT, '0);
      5'd17: w = mk_cw(MA_K,   MB_MS,  OP_SGN,     SH_0,  WR_NONE, J_NEXT, '0);
      5'd18: w = mk_cw(MA_K,   MB_MS,  OP_VADD,    SH_0,  WR_NONE, J_NEXT, '0);
      5'd19: w = mk_cw(MA_VL,  MB_MS,  OP_NOP,     SH_0,  WR_NONE, J_NEXT, '0);
      5'd20: w = mk_cw(MA_VH,  MB_MS,  OP_LD,      SH_0,  WR_NONE, J_NEXT, '0);
      5'd21: w = mk_cw(MA_K,   MB_MS,  OP_ADD,     SH_24, WR_NONE, J_NEXT, '0);
      5'd22: w = mk_cw(MA_K,   MB_MS,  OP_ABS,     SH_0,  WR_NONE, J_NEXT, '0);
      5'd23: w = mk_cw(MA_K,   MB_MS,  OP_DIVPREP, SH_0,  WR_NONE, J_NEXT, '0);
      5'd24: w = mk_cw(MA_K,   MB_MS,  OP_DIV,     SH_0,  WR_NONE, J_DIV,  PcDiv);
      5'd25: w = mk_cw(MA_K,   MB_MS,  OP_SGN,     SH_0,  WR_NONE, J_NEXT, '0);
      5'd26: w = mk_cw(MA_K,   MB_MS,  OP_PADD,    SH_0,  WR_NONE, J_LOOP, PcALoop);
      default: w = mk_cw(MA_K, MB_MS,  OP_NOP,     SH_0,  WR_NONE, J_DONE, '0);
    endcase
    return w;
  endfunction

endpackage

### src/imu_dead_reckoning_step_top.sv
// Top level of the IMU dead-reckoning step: microcoded sequencer driving one shared multiplier.
// Depends on imu_drs_pkg for widths, constants and the microcode ROM.
//
// Channel | Signals                                   | Transfer
// input   | in_valid_i, in_stall_o, quat_*, accel_*   | valid high and stall low at clk edge
// output  | out_valid_o, out_stall_i, pos_*, saturated| valid high and stall low at clk edge
// config  | cfg_we_i, cfg_wdata_i                     | write enable high at clk edge
//
// A transaction runs through 2 setup steps, 3 steps per axis for the first cross product, and
// 28 steps per axis for rotation, integration and the divide by 1000, which retires 8 quotient
// bits per cycle. The input stays stalled from acceptance until the result is loaded. The 36x16
// multiplier is shared by every product. A finished result waits in the output register, and
// the sequencer holds in its last step while that register is full and stalled. Reset clears
// velocity, position and the handshakes and sets the threshold to 41.
module imu_dead_reckoning_step_top
  import imu_drs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ThrW-1:0]          cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [15:0]       quat_w_i,
  input  logic signed [15:0]       quat_x_i,
  input  logic signed [15:0]       quat_y_i,
  input  logic signed [15:0]       quat_z_i,
  input  logic signed [15:0]       accel_x_i,
  input  logic signed [15:0]       accel_y_i,
  input  logic signed [15:0]       accel_z_i,
  input  logic [MsW-1:0]           elapsed_ms_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [StW-1:0]    pos_x_o,
  output logic signed [StW-1:0]    pos_y_o,
  output logic signed [StW-1:0]    pos_z_o,
  output logic                     saturated_o
);

  logic                    busy_q, busy_d;
  logic [PcW-1:0]          pc_q, pc_d;
  logic [1:0]              axis_q, axis_d, axis_j, axis_k;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    sign_q, sign_d;
  logic                    sat_q;
  logic                    out_valid_q;
  logic                    out_load;
  logic                    accept;
  logic [ThrW-1:0]         thr_q;

  logic signed [15:0]      qw_q;
  logic signed [15:0]      u_q [3];
  logic signed [15:0]      a_q [3];
  logic [MsW-1:0]          ms_q;
  logic signed [TW-1:0]    t_q [3];
  logic signed [XW-1:0]    x_q;
  logic [MkW-1:0]          mk_q;
  logic signed [StW-1:0]   vel_q [3];
  logic signed [StW-1:0]   pos_q [3];
  logic signed [StW-1:0]   pos_out_q [3];
  logic                    sat_out_q;

  logic signed [AccW-1:0]  acc_q, acc_d;
  logic [6:0]              rem_q, rem_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [AccW-1:0]  p_ext, p_sh;
  logic signed [AccW-1:0]  acc_mag;
  logic signed [AccW-1:0]  thr_big;
  logic signed [AccW-1:0]  accel_base;
  logic [AccW-1:0]         rnd16, rnd28, divprep;
  logic [7:0]              qbyte;
  logic signed [StW-1:0]   st_cur, st_new;
  logic signed [AccW-1:0]  st_sum;
  logic                    st_ovf;
  ctrl_t                   cw;

  assign accept     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;
  assign cw         = ucode(pc_q);
  assign axis_j     = nxt_axis(axis_q);
  assign axis_k     = prv_axis(axis_q);

  always_comb begin
    unique case (cw.mul_a)
      MA_T_I:  mul_a = MulAW'(t_q[axis_q]);
      MA_T_J:  mul_a = MulAW'(t_q[axis_j]);
      MA_T_K:  mul_a = MulAW'(t_q[axis_k]);
      MA_A_J:  mul_a = MulAW'(a_q[axis_j]);
      MA_A_K:  mul_a = MulAW'(a_q[axis_k]);
      MA_X:    mul_a = MulAW'(x_q);
      MA_VL:   mul_a = MulAW'($signed({1'b0, vel_q[axis_q][23:0]}));
      MA_VH:   mul_a = MulAW'($signed(vel_q[axis_q][StW-1:24]));
      MA_K:    mul_a = MulAW'($signed({1'b0, VelK}));
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (cw.mul_b)
      MB_QW:   mul_b = qw_q;
      MB_U_J:  mul_b = u_q[axis_j];
      MB_U_K:  mul_b = u_q[axis_k];
      MB_MS:   mul_b = MulBW'($signed({1'b0, ms_q}));
      MB_MKL:  mul_b = MulBW'($signed({1'b0, mk_q[MkHalf-1:0]}));
      MB_MKH:  mul_b = MulBW'($signed({1'b0, mk_q[MkW-1:MkHalf]}));
      default: mul_b = '0;
    endcase
  end

  assign prod_d = ProdW'(mul_a) * ProdW'(mul_b);
  assign p_ext  = AccW'(prod_q);

  always_comb begin
    case (cw.sh)
      SH_0:    p_sh = p_ext;
      SH_1:    p_sh = p_ext <<< 1;
      SH_14:   p_sh = p_ext <<< 14;
      SH_24:   p_sh = p_ext <<< 24;
      default: p_sh = p_ext;
    endcase
  end

  assign acc_mag    = acc_q[AccW-1] ? -acc_q : acc_q;
  assign thr_big    = $signed(AccW'({thr_q, 28'd0}));
  assign accel_base = (AccW'(a_q[axis_q]) <<< 28) + ((axis_q == 2'd2) ? OneG : '0);
  assign rnd16      = ($unsigned(acc_q) + RndHalf16) >> 16;
  assign rnd28      = ($unsigned(acc_q) + RndHalf28) >> 28;
  assign divprep    = ($unsigned(acc_q) + DivBias) >> DivPre;

  // Restoring division by 125 over the top byte of the dividend window.
  always_comb begin
    logic [7:0] r2;
    logic [6:0] r;
    r = rem_q;
    qbyte = '0;
    for (int b = 7; b >= 0; b--) begin
      r2 = {r, acc_q[48 + b]};
      if (r2 >= {1'b0, DivBase}) begin
        qbyte[b] = 1'b1;
        r2 = r2 - {1'b0, DivBase};
      end
      r = r2[6:0];
    end
    rem_d = r;
  end

  always_comb begin
    acc_d  = acc_q;
    sign_d = sign_q;
    cnt_d  = cnt_q;
    unique case (cw.op) inside
      OP_NOP, OP_VADD, OP_PADD: ;
      OP_LD:    acc_d = p_sh;
      OP_ADD:   acc_d = acc_q + p_sh;
      OP_SUB:   acc_d = acc_q - p_sh;
      OP_ACCEL: acc_d = accel_base + p_sh;
      OP_ABS: begin
        acc_d  = acc_mag;
        sign_d = acc_q[AccW-1];
      end
      OP_ABSDB: begin
        acc_d  = (acc_mag < thr_big) ? '0 : acc_mag;
        sign_d = acc_q[AccW-1];
      end
      OP_RND16: acc_d = $signed(rnd16);
      OP_RND28: acc_d = $signed(rnd28);
      OP_DIVPREP: begin
        acc_d = $signed(divprep);
        cnt_d = DivLast;
      end
      OP_DIV: begin
        acc_d = $signed({8'd0, acc_q[47:0], qbyte});
        cnt_d = cnt_q - 3'd1;
      end
      OP_SGN:   acc_d = sign_q ? -acc_q : acc_q;
      default: ;
    endcase
  end

  assign st_cur = (cw.op == OP_PADD) ? pos_q[axis_q] : vel_q[axis_q];
  assign st_sum = AccW'(st_cur) + acc_q;

  always_comb begin
    st_ovf = 1'b0;
    st_new = st_sum[StW-1:0];
    if (st_sum > StMax) begin
      st_ovf = 1'b1;
      st_new = StMax[StW-1:0];
    end else if (st_sum < StMin) begin
      st_ovf = 1'b1;
      st_new = StMin[StW-1:0];
    end
  end

  always_comb begin
    pc_d     = pc_q;
    axis_d   = axis_q;
    busy_d   = busy_q;
    out_load = 1'b0;
    if (accept) begin
      pc_d   = '0;
      axis_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      unique case (cw.jmp)
        J_NEXT: pc_d = pc_q + 5'd1;
        J_LOOP: begin
          if (axis_q == 2'd2) begin
            axis_d = '0;
            pc_d   = pc_q + 5'd1;
          end else begin
            axis_d = axis_q + 2'd1;
            pc_d   = cw.target;
          end
        end
        J_DIV: pc_d = (cnt_q != '0) ? cw.target : pc_q + 5'd1;
        J_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_load = 1'b1;
            busy_d   = 1'b0;
          end
        end
        default: pc_d = pc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      axis_q      <= '0;
      cnt_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      thr_q       <= ThrReset;
      for (int i = 0; i < 3; i++) begin
        vel_q[i] <= '0;
        pos_q[i] <= '0;
      end
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
      axis_q <= axis_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (accept) begin
        sat_q <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_d;
        if (cw.op == OP_VADD) begin
          vel_q[axis_q] <= st_new;
          sat_q         <= sat_q | st_ovf;
        end
        if (cw.op == OP_PADD) begin
          pos_q[axis_q] <= st_new;
          sat_q         <= sat_q | st_ovf;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (accept) begin
      qw_q   <= quat_w_i;
      u_q[0] <= quat_x_i;
      u_q[1] <= quat_y_i;
      u_q[2] <= quat_z_i;
      a_q[0] <= accel_x_i;
      a_q[1] <= accel_y_i;
      a_q[2] <= accel_z_i;
      ms_q   <= elapsed_ms_i;
    end
    if (busy_q) begin
      acc_q  <= acc_d;
      sign_q <= sign_d;
      if (cw.op == OP_DIVPREP) begin
        rem_q <= '0;
      end else if (cw.op == OP_DIV) begin
        rem_q <= rem_d;
      end
      unique case (cw.wr)
        WR_NONE: ;
        WR_T:    t_q[axis_q] <= acc_d[TW-1:0];
        WR_X:    x_q <= acc_d[XW-1:0];
        WR_MK:   mk_q <= acc_d[MkW-1:0];
        default: ;
      endcase
    end
    if (out_load) begin
      for (int i = 0; i < 3; i++) begin
        pos_out_q[i] <= pos_q[i];
      end
      sat_out_q <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_out_q[0];
  assign pos_y_o     = pos_out_q[1];
  assign pos_z_o     = pos_out_q[2];
  assign saturated_o = sat_out_q;

endmodule

### src/imu_drs_checker.sv
// Port-level checker for the IMU dead-reckoning step and its bind to the top level.
// Depends on imu_dead_reckoning_step_top_defines.svh for the assertion macros.
`include "imu_dead_reckoning_step_top_defines.svh"

module imu_drs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [47:0] pos_x_o,
  input logic signed [47:0] pos_y_o,
  input logic signed [47:0] pos_z_o,
  input logic               saturated_o
);

  // A stalled result must stay in place until the transaction completes.
  `IDRS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(pos_x_o) && $stable(pos_y_o) && $stable(pos_z_o) && $stable(saturated_o), "result changed while stalled")

  // The block works on one transaction at a time.
  `IDRS_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "input not stalled after acceptance")

  // A new result appears exactly when the sequencer frees the input side.
  `IDRS_ASSERT(a_result_ends_work, $rose(out_valid_o) |-> $fell(in_stall_o), "result without end of work")

  `IDRS_ASSERT_RST(a_reset_idle, !rst_ni |=> !out_valid_o && !in_stall_o, "not idle after reset")

endmodule

bind imu_dead_reckoning_step_top imu_drs_checker u_imu_drs_checker (.*);

### bench/tb.sv
// Self-checking testbench for imu_dead_reckoning_step_top: directed, random, stall and saturation runs.
// Depends on imu_drs_pkg and the RTL. Every result is checked against a predictor kept in this file.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import imu_drs_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int HoldCycles = 1500;
  localparam int SettleCycles = 200;
  localparam int unsigned DeadbandAtReset = 41;
  localparam longint GainPerMs = 164584;
  localparam longint OneGee = 64'sd1 <<< 40;
  localparam longint PosMax = (64'sd1 <<< 47) - 1;
  localparam longint PosMin = -(64'sd1 <<< 47);

  typedef struct packed {
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [MsW-1:0]     ms;
  } imu_sample_t;

  typedef struct packed {
    logic signed [StW-1:0] px;
    logic signed [StW-1:0] py;
    logic signed [StW-1:0] pz;
    logic                  sat;
  } nav_fix_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [ThrW-1:0]       cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic signed [15:0]    quat_w_i = '0;
  logic signed [15:0]    quat_x_i = '0;
  logic signed [15:0]    quat_y_i = '0;
  logic signed [15:0]    quat_z_i = '0;
  logic signed [15:0]    accel_x_i = '0;
  logic signed [15:0]    accel_y_i = '0;
  logic signed [15:0]    accel_z_i = '0;
  logic [MsW-1:0]        elapsed_ms_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [StW-1:0] pos_x_o;
  logic signed [StW-1:0] pos_y_o;
  logic signed [StW-1:0] pos_z_o;
  logic                  saturated_o;

  longint      velocity_state[3] = '{0, 0, 0};
  longint      position_state[3] = '{0, 0, 0};
  int unsigned deadband_model = DeadbandAtReset;
  nav_fix_t    pending_positions[$];
  int          err_count = 0;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  int          hold_asked = 0;
  int          hold_taken = 0;
  int          hold_left = 0;
  int          stuck_cycles = 0;

  imu_dead_reckoning_step_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .quat_w_i     (quat_w_i),
    .quat_x_i     (quat_x_i),
    .quat_y_i     (quat_y_i),
    .quat_z_i     (quat_z_i),
    .accel_x_i    (accel_x_i),
    .accel_y_i    (accel_y_i),
    .accel_z_i    (accel_z_i),
    .elapsed_ms_i (elapsed_ms_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .pos_z_o      (pos_z_o),
    .saturated_o  (saturated_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint round_half_away(longint v, int sh);
    logic [63:0] mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint div1000_round(longint v);
    logic [63:0] mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + 64'd500) / 64'd1000;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clamp_state(longint v, inout bit hit);
    if (v > PosMax) begin
      hit = 1'b1;
      return PosMax;
    end
    if (v < PosMin) begin
      hit = 1'b1;
      return PosMin;
    end
    return v;
  endfunction

  // Rotates the sample into the world frame, removes gravity, applies the deadband and
  // advances velocity and position.
  function automatic nav_fix_t dead_reckon(imu_sample_t s);
    longint w, ms, thr, a24, dv, dp;
    longint u[3], a[3], t[3], c[3], wa[3];
    bit hit;
    int i;
    nav_fix_t f;
    w = s.qw;
    u[0] = s.qx;
    u[1] = s.qy;
    u[2] = s.qz;
    a[0] = s.ax;
    a[1] = s.ay;
    a[2] = s.az;
    ms = s.ms;
    thr = longint'(deadband_model) <<< 28;
    hit = 1'b0;
    t[0] = u[1] * a[2] - u[2] * a[1];
    t[1] = u[2] * a[0] - u[0] * a[2];
    t[2] = u[0] * a[1] - u[1] * a[0];
    c[0] = u[1] * t[2] - u[2] * t[1];
    c[1] = u[2] * t[0] - u[0] * t[2];
    c[2] = u[0] * t[1] - u[1] * t[0];
    for (i = 0; i < 3; i++) wa[i] = (a[i] <<< 28) + 2 * (w * t[i] + c[i]);
    wa[2] += OneGee;
    for (i = 0; i < 3; i++) begin
      if (((wa[i] < 0) ? -wa[i] : wa[i]) < thr) wa[i] = 0;
      a24 = round_half_away(wa[i], 16);
      dv = round_half_away(a24 * ms * GainPerMs, 28);
      velocity_state[i] = clamp_state(velocity_state[i] + dv, hit);
      dp = div1000_round(velocity_state[i] * ms);
      position_state[i] = clamp_state(position_state[i] + dp, hit);
    end
    f.px = StW'(position_state[0]);
    f.py = StW'(position_state[1]);
    f.pz = StW'(position_state[2]);
    f.sat = hit;
    return f;
  endfunction

  function automatic imu_sample_t mk_sample(int qw, int qx, int qy, int qz,
                                            int ax, int ay, int az, int ms);
    imu_sample_t s;
    s.qw = 16'(qw);
    s.qx = 16'(qx);
    s.qy = 16'(qy);
    s.qz = 16'(qz);
    s.ax = 16'(ax);
    s.ay = 16'(ay);
    s.az = 16'(az);
    s.ms = MsW'(ms);
    return s;
  endfunction

  function automatic int edge_value16();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return 1;
      4: return 32767;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Four in ten samples are plausible motion: a rotation about world z with gravity on body z and small
  // horizontal accelerations around the deadband. The rest is raw noise and edge values.
  function automatic imu_sample_t random_sample();
    imu_sample_t s;
    int kind, span, cs, sn;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      s = mk_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 1023));
    end else if (kind < 8) begin
      case ($urandom_range(0, 4))
        0: begin cs = 16384; sn = 0; end
        1: begin cs = 11585; sn = 11585; end
        2: begin cs = 0; sn = 16384; end
        3: begin cs = 11585; sn = -11585; end
        default: begin cs = 15137; sn = 6270; end
      endcase
      span = deadband_model + 2;
      if (span > 20000) span = 20000;
      s = mk_sample(cs + int'($urandom_range(0, 8)) - 4, 0, 0,
                    sn + int'($urandom_range(0, 8)) - 4,
                    int'($urandom_range(0, 2 * span)) - span,
                    int'($urandom_range(0, 2 * span)) - span,
                    -4096 + int'($urandom_range(0, 2 * span)) - span,
                    $urandom_range(1, 1023));
    end else begin
      s = mk_sample(edge_value16(), edge_value16(), edge_value16(), edge_value16(),
                    edge_value16(), edge_value16(), edge_value16(),
                    ($urandom_range(0, 1) == 0) ? 1023 : $urandom_range(0, 1));
    end
    return s;
  endfunction

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_position();
    nav_fix_t want;
    if (pending_positions.size() == 0) begin
      flag_error($sformatf("unexpected transaction pos=(%0d,%0d,%0d) sat=%0b",
                           pos_x_o, pos_y_o, pos_z_o, saturated_o));
    end else begin
      want = pending_positions.pop_front();
      if (pos_x_o !== want.px || pos_y_o !== want.py || pos_z_o !== want.pz ||
          saturated_o !== want.sat) begin
        flag_error($sformatf("expected pos=(%0d,%0d,%0d) sat=%0b, got pos=(%0d,%0d,%0d) sat=%0b",
                             want.px, want.py, want.pz, want.sat,
                             pos_x_o, pos_y_o, pos_z_o, saturated_o));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_position();
    if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < snk_stall_pct);
    end
  end

  initial begin
    while (stuck_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
    end
    $display("imu_dead_reckoning_step_top: mismatch");
    $finish;
  end

  task automatic send_sample(imu_sample_t s);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    quat_w_i     <= s.qw;
    quat_x_i     <= s.qx;
    quat_y_i     <= s.qy;
    quat_z_i     <= s.qz;
    accel_x_i    <= s.ax;
    accel_y_i    <= s.ay;
    accel_z_i    <= s.az;
    elapsed_ms_i <= s.ms;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_positions.push_back(dead_reckon(s));
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_deadband(int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ThrW'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    deadband_model = value;
  endtask

  task automatic test_directed();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    send_sample(mk_sample(16384, 0, 0, 0, 0, 0, 0, 0));
    send_sample(mk_sample(16384, 0, 0, 0, 0, 0, -4096, 1023));
    send_sample(mk_sample(16384, 0, 0, 0, 41, 40, -4096 - 41, 1000));
    send_sample(mk_sample(16384, 0, 0, 0, -41, -40, -4096 + 40, 10));
    send_sample(mk_sample(32767, 32767, 32767, 32767, 32767, 32767, 32767, 1023));
    send_sample(mk_sample(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 1023));
    send_sample(mk_sample(0, 0, 0, 0, 1000, -1000, 0, 1));
    send_sample(mk_sample(32767, 0, 0, 0, 4096, 0, 0, 500));
    send_sample(mk_sample(11585, 11585, 0, 0, 0, 4096, 0, 100));
    send_sample(mk_sample(0, 0, 16384, 0, 4096, 2048, -4096, 250));
    send_sample(mk_sample(-32768, 32767, -1, 1, 32767, -32768, 1, 1023));
    send_sample(mk_sample(32767, -32768, 32767, -32768, 32767, 32767, -32768, 0));
    send_sample(mk_sample(16384, 0, 0, 0, 3, -3, -4093, 1));
    send_sample(mk_sample(15137, 0, 0, 6270, -2048, 1024, -4096, 777));
    send_sample(mk_sample(-16384, 0, 0, 0, 0, 0, -4096, 512));
    wait_for_results();
  endtask

  task automatic test_random_phase(int src_pct, int snk_pct, int unsigned thr, int count);
    wait_for_results();
    write_deadband(thr);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    repeat (count) send_sample(random_sample());
    wait_for_results();
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_asked++;
    repeat (8) send_sample(random_sample());
    wait_for_results();
  endtask

  // A large non-unit quaternion drives world x up and world y down until both positions clamp.
  task automatic test_saturation();
    src_idle_pct = 18;
    snk_stall_pct = 18;
    repeat (360) begin
      send_sample(mk_sample(-32768, -32768, -32768, -32768,
                            -32768 + int'($urandom_range(0, 15)), 32767, 32767,
                            $urandom_range(1000, 1023)));
    end
    wait_for_results();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(0, 0, 0, 112);
    test_random_phase(65, 0, 32767, 112);
    test_random_phase(0, 65, $urandom_range(1, 32766), 112);
    test_random_phase(18, 18, DeadbandAtReset, 112);
    test_backpressure();
    test_saturation();
    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (err_count == 0 && pending_positions.size() == 0) begin
      $display("imu_dead_reckoning_step_top: match");
    end else begin
      $display("imu_dead_reckoning_step_top: mismatch");
    end
    $finish;
  end

endmodule
